@@ src/sample_count_to_timecode_macros.svh @@
// ----------------------------------------------------------------------------
// sample_count_to_timecode_macros.svh
// assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef SAMPLE_COUNT_TO_TIMECODE_MACROS_SVH
`define SAMPLE_COUNT_TO_TIMECODE_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define STC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is active
`define STC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// stc_pkg
// shared widths, stage counts, types and helper functions of the timecode block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

	// field widths
	localparam int POSITION_BITS = 40;
	localparam int RATE_W        = 20;
	localparam int MODE_W        = 2;
	localparam int SEC_W         = 32;
	localparam int HOURS_W       = 8;
	localparam int MS_W          = 6;
	localparam int CFG_INDEX_W   = 1;

	// x / 60 == (x * DIV60_MAGIC) >> DIV60_SHIFT for every 32-bit x
	localparam logic [SEC_W-1:0] DIV60_MAGIC = 32'h8888_8889;
	localparam int DIV60_SHIFT   = 37;
	// minute count of a 32-bit second count
	localparam int MIN_W         = 2*SEC_W - DIV60_SHIFT;

	// hour split: three stages, then padded to match the fraction path
	localparam int HMS_STAGES    = 3;

	// fraction path: multiply stage, then one stage per quotient bit
	localparam int FRAC_DIV_STAGES = RATE_W;
	localparam int FRAC_STAGES     = FRAC_DIV_STAGES + 1;
	localparam int HMS_PAD         = FRAC_STAGES - HMS_STAGES;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRACTION_MODE = 1'b1;

	// fraction modes
	localparam logic [MODE_W-1:0] MODE_SAMPLES = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MSEC    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FRAMES  = 2'd2;

	localparam int MSEC_UNIT     = 1000;
	localparam int FRAMES_UNIT   = 30;
	localparam int RESET_RATE    = 48000;
	localparam int SIXTY         = 60;

	// control that travels with every item
	typedef struct packed {
		logic valid;
		logic neg;
	} ctl_t;

	// one finished result
	typedef struct packed {
		logic                negative;
		logic [HOURS_W-1:0]  hours;
		logic [MS_W-1:0]     minutes;
		logic [MS_W-1:0]     seconds;
		logic [RATE_W-1:0]   fraction;
		logic [RATE_W-1:0]   frac_steps;
	} res_t;

	// fraction steps per second for a mode; unused mode counts samples
	function automatic logic [RATE_W-1:0] unit_for_mode(
		input logic [MODE_W-1:0] mode,
		input logic [RATE_W-1:0] rate
	);
		logic [RATE_W-1:0] u;
		case (mode)
			MODE_MSEC:   u = RATE_W'(MSEC_UNIT);
			MODE_FRAMES: u = RATE_W'(FRAMES_UNIT);
			default:     u = rate;
		endcase
		return u;
	endfunction

	// one restoring division step by the sample rate: returns {quotient bit, remainder}
	function automatic logic [RATE_W:0] div_step(
		input logic [RATE_W-1:0] r,
		input logic              b,
		input logic [RATE_W-1:0] d
	);
		logic [RATE_W:0] t;
		logic [RATE_W:0] diff;
		t    = {r, b};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			return {1'b1, diff[RATE_W-1:0]};
		end
		return {1'b0, t[RATE_W-1:0]};
	endfunction

endpackage

`default_nettype wire

@@ src/stc_sec_div.sv @@
// ----------------------------------------------------------------------------
// stc_sec_div
// pipelined restoring divider: magnitude by sample rate, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stc_sec_div
	import stc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [RATE_W-1:0]        rate,
	input  ctl_t                     src_ctl,
	input  logic [POSITION_BITS-1:0] mag,
	output ctl_t                     res_ctl,
	output logic [SEC_W-1:0]         sec,
	output logic [RATE_W-1:0]        rem
);

	logic [POSITION_BITS-1:0] word_s  [POSITION_BITS];
	logic [RATE_W-1:0]        rem_s   [POSITION_BITS];
	ctl_t                     ctl_s   [POSITION_BITS];
	logic [POSITION_BITS-1:0] src_word[POSITION_BITS];
	logic [RATE_W-1:0]        src_rem [POSITION_BITS];
	logic [POSITION_BITS-1:0] word_nx [POSITION_BITS];
	logic [RATE_W-1:0]        rem_nx  [POSITION_BITS];

	// stage inputs
	always_comb begin
		src_word[0] = mag;
		src_rem[0]  = '0;
		for (int k = 1; k < POSITION_BITS; k++) begin
			src_word[k] = word_s[k-1];
			src_rem[k]  = rem_s[k-1];
		end
	end

	// one compare and subtract per stage, quotient bits shift in from the right
	always_comb begin
		logic [RATE_W:0] st;
		for (int k = 0; k < POSITION_BITS; k++) begin
			st         = div_step(src_rem[k], src_word[k][POSITION_BITS-1], rate);
			word_nx[k] = {src_word[k][POSITION_BITS-2:0], st[RATE_W]};
			rem_nx[k]  = st[RATE_W-1:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < POSITION_BITS; k++) begin
				word_s[k] <= word_nx[k];
				rem_s[k]  <= rem_nx[k];
			end
		end
	end

	// control travels alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < POSITION_BITS; k++) begin
				ctl_s[k] <= '0;
			end
		end else if (en) begin
			ctl_s[0] <= src_ctl;
			for (int k = 1; k < POSITION_BITS; k++) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	// whole seconds truncated to 32 bits
	assign res_ctl = ctl_s[POSITION_BITS-1];
	assign sec     = word_s[POSITION_BITS-1][SEC_W-1:0];
	assign rem     = rem_s[POSITION_BITS-1];

endmodule

`default_nettype wire

@@ src/stc_hms.sv @@
// ----------------------------------------------------------------------------
// stc_hms
// splits the second count into hours, minutes and seconds by reciprocal multiplies
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stc_hms
	import stc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ctl_t               src_ctl,
	input  logic [SEC_W-1:0]   sec,
	output ctl_t               res_ctl,
	output logic [HOURS_W-1:0] hours,
	output logic [MS_W-1:0]    minutes,
	output logic [MS_W-1:0]    seconds
);

	logic [2*SEC_W-1:0] sec_prod;
	logic [2*SEC_W-1:0] min_prod;
	logic [SEC_W-1:0]   sec_left;
	logic [MIN_W-1:0]   min_left;

	ctl_t               ctl_s1;
	ctl_t               ctl_s2;
	ctl_t               ctl_s3;
	logic [SEC_W-1:0]   sec_s1;
	logic [MIN_W-1:0]   min_s1;
	logic [MIN_W-1:0]   min_s2;
	logic [MIN_W-1:0]   hr_s2;
	logic [MS_W-1:0]    secs_s2;
	logic [MS_W-1:0]    secs_s3;
	logic [MS_W-1:0]    mins_s3;
	logic [HOURS_W-1:0] hrs_s3;

	// delay line that lines the split up with the fraction path
	ctl_t               pctl_s [HMS_PAD];
	logic [HOURS_W-1:0] phrs_s [HMS_PAD];
	logic [MS_W-1:0]    pmins_s[HMS_PAD];
	logic [MS_W-1:0]    psecs_s[HMS_PAD];

	// quotients by 60 through the reciprocal, exact for any 32-bit count
	assign sec_prod = (2*SEC_W)'(sec) * (2*SEC_W)'(DIV60_MAGIC);
	assign min_prod = (2*SEC_W)'(min_s1) * (2*SEC_W)'(DIV60_MAGIC);

	// remainders: count minus quotient times 60
	assign sec_left = sec_s1 - SEC_W'(min_s1) * SEC_W'(SIXTY);
	assign min_left = min_s2 - hr_s2 * MIN_W'(SIXTY);

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			sec_s1  <= sec;
			min_s1  <= sec_prod[2*SEC_W-1:DIV60_SHIFT];
			min_s2  <= min_s1;
			hr_s2   <= min_prod[2*SEC_W-1:DIV60_SHIFT];
			secs_s2 <= sec_left[MS_W-1:0];
			secs_s3 <= secs_s2;
			mins_s3 <= min_left[MS_W-1:0];
			hrs_s3  <= hr_s2[HOURS_W-1:0];
			phrs_s[0]  <= hrs_s3;
			pmins_s[0] <= mins_s3;
			psecs_s[0] <= secs_s3;
			for (int k = 1; k < HMS_PAD; k++) begin
				phrs_s[k]  <= phrs_s[k-1];
				pmins_s[k] <= pmins_s[k-1];
				psecs_s[k] <= psecs_s[k-1];
			end
		end
	end

	// control travels alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			for (int k = 0; k < HMS_PAD; k++) begin
				pctl_s[k] <= '0;
			end
		end else if (en) begin
			ctl_s1    <= src_ctl;
			ctl_s2    <= ctl_s1;
			ctl_s3    <= ctl_s2;
			pctl_s[0] <= ctl_s3;
			for (int k = 1; k < HMS_PAD; k++) begin
				pctl_s[k] <= pctl_s[k-1];
			end
		end
	end

	// hours wrap modulo 256
	assign res_ctl = pctl_s[HMS_PAD-1];
	assign hours   = phrs_s[HMS_PAD-1];
	assign minutes = pmins_s[HMS_PAD-1];
	assign seconds = psecs_s[HMS_PAD-1];

endmodule

`default_nettype wire

@@ src/stc_frac.sv @@
// ----------------------------------------------------------------------------
// stc_frac
// rescales the remainder within the second: multiply by the unit, divide by the rate
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stc_frac
	import stc_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [RATE_W-1:0] rate,
	input  logic [MODE_W-1:0] mode,
	input  logic [RATE_W-1:0] rem,
	output logic [RATE_W-1:0] fraction
);

	logic [2*RATE_W-1:0] prod_s1;
	logic [RATE_W-1:0]   fword_s [FRAC_DIV_STAGES];
	logic [RATE_W-1:0]   frem_s  [FRAC_DIV_STAGES];
	logic [RATE_W-1:0]   src_word[FRAC_DIV_STAGES];
	logic [RATE_W-1:0]   src_rem [FRAC_DIV_STAGES];
	logic [RATE_W-1:0]   fword_nx[FRAC_DIV_STAGES];
	logic [RATE_W-1:0]   frem_nx [FRAC_DIV_STAGES];

	// stage inputs; the upper product half is already below the rate
	always_comb begin
		src_word[0] = prod_s1[RATE_W-1:0];
		src_rem[0]  = prod_s1[2*RATE_W-1:RATE_W];
		for (int k = 1; k < FRAC_DIV_STAGES; k++) begin
			src_word[k] = fword_s[k-1];
			src_rem[k]  = frem_s[k-1];
		end
	end

	// one quotient bit per stage, truncating toward zero
	always_comb begin
		logic [RATE_W:0] st;
		for (int k = 0; k < FRAC_DIV_STAGES; k++) begin
			st          = div_step(src_rem[k], src_word[k][RATE_W-1], rate);
			fword_nx[k] = {src_word[k][RATE_W-2:0], st[RATE_W]};
			frem_nx[k]  = st[RATE_W-1:0];
		end
	end

	// multiply, then divide
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (2*RATE_W)'(rem) * (2*RATE_W)'(unit_for_mode(mode, rate));
			for (int k = 0; k < FRAC_DIV_STAGES; k++) begin
				fword_s[k] <= fword_nx[k];
				frem_s[k]  <= frem_nx[k];
			end
		end
	end

	assign fraction = fword_s[FRAC_DIV_STAGES-1];

endmodule

`default_nettype wire

@@ src/sample_count_to_timecode.sv @@
// ----------------------------------------------------------------------------
// sample_count_to_timecode
// converts a signed sample position into sign, hours, minutes, seconds and fraction
// ----------------------------------------------------------------------------
//  channel   | signals                                   | direction
//  position  | position_valid, position_stall, position  | in
//  result    | result_valid, result_stall, negative,     | out
//            | hours, minutes, seconds, fraction,        |
//            | frac_steps                                |
//  config    | cfg_we, cfg_index, cfg_data               | in
//
//  throughput: one item per cycle while position_stall is low
//  path from accept to result_valid: sign stage, one-bit-per-stage division
//    by the sample rate, fraction multiply and divider (hour split runs
//    alongside), result register
//  reset: rate 48000, fraction_mode samples; no memory, no clearing pass
//  stalls: a stalled result moves to a skid register and position_stall rises
//    the next cycle; it drops at the edge that takes the skid item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sample_count_to_timecode
	import stc_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [CFG_INDEX_W-1:0]          cfg_index,
	input  logic [RATE_W-1:0]               cfg_data,
	// position channel
	input  logic                            position_valid,
	output logic                            position_stall,
	input  logic signed [POSITION_BITS-1:0] position,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            negative,
	output logic [HOURS_W-1:0]              hours,
	output logic [MS_W-1:0]                 minutes,
	output logic [MS_W-1:0]                 seconds,
	output logic [RATE_W-1:0]               fraction,
	output logic [RATE_W-1:0]               frac_steps
);

	logic [RATE_W-1:0]        rate_q;
	logic [MODE_W-1:0]        fraction_mode_q;
	logic                     en;
	logic [POSITION_BITS-1:0] pos_u;
	ctl_t                     ctl_s1;
	logic [POSITION_BITS-1:0] mag_s1;
	ctl_t                     div_ctl;
	logic [SEC_W-1:0]         div_sec;
	logic [RATE_W-1:0]        div_rem;
	ctl_t                     hms_ctl;
	logic [HOURS_W-1:0]       hms_hours;
	logic [MS_W-1:0]          hms_minutes;
	logic [MS_W-1:0]          hms_seconds;
	logic [RATE_W-1:0]        frac_val;
	logic                     rate_zero;
	res_t                     res_nx;
	logic                     res_v_s;
	res_t                     res_s;
	logic                     skid_v_q;
	res_t                     skid_q;
	res_t                     out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q          <= RATE_W'(RESET_RATE);
			fraction_mode_q <= MODE_SAMPLES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_RATE:   rate_q          <= cfg_data;
				REG_FRACTION_MODE: fraction_mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// the whole pipeline moves unless the skid register holds an item
	assign en             = !skid_v_q;
	assign position_stall = skid_v_q;

	// sign and magnitude; the most negative value keeps its magnitude as unsigned
	assign pos_u = $unsigned(position);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= position_valid;
			ctl_s1.neg   <= pos_u[POSITION_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= pos_u[POSITION_BITS-1] ? (~pos_u + POSITION_BITS'(1)) : pos_u;
		end
	end

	// whole seconds and remainder
	stc_sec_div u_sec_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.rate    (rate_q),
		.src_ctl (ctl_s1),
		.mag     (mag_s1),
		.res_ctl (div_ctl),
		.sec     (div_sec),
		.rem     (div_rem)
	);

	// hours, minutes, seconds
	stc_hms u_hms (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.src_ctl (div_ctl),
		.sec     (div_sec),
		.res_ctl (hms_ctl),
		.hours   (hms_hours),
		.minutes (hms_minutes),
		.seconds (hms_seconds)
	);

	// fraction in the chosen unit
	stc_frac u_frac (
		.clk      (clk),
		.en       (en),
		.rate     (rate_q),
		.mode     (fraction_mode_q),
		.rem      (div_rem),
		.fraction (frac_val)
	);

	// a zero rate clears every divided field
	assign rate_zero = (rate_q == '0);

	always_comb begin
		res_nx.negative   = hms_ctl.neg;
		res_nx.hours      = rate_zero ? '0 : hms_hours;
		res_nx.minutes    = rate_zero ? '0 : hms_minutes;
		res_nx.seconds    = rate_zero ? '0 : hms_seconds;
		res_nx.fraction   = rate_zero ? '0 : frac_val;
		res_nx.frac_steps = unit_for_mode(fraction_mode_q, rate_q);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s <= 1'b0;
		end else if (en) begin
			res_v_s <= hms_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s <= res_nx;
		end
	end

	// skid register catches the item shown while the result side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!result_stall) begin
				skid_v_q <= 1'b0;
			end
		end else if (res_v_s && result_stall) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_q <= res_s;
		end
	end

	// result channel
	assign result_valid = skid_v_q | res_v_s;
	assign out_res      = skid_v_q ? skid_q : res_s;
	assign negative     = out_res.negative;
	assign hours        = out_res.hours;
	assign minutes      = out_res.minutes;
	assign seconds      = out_res.seconds;
	assign fraction     = out_res.fraction;
	assign frac_steps   = out_res.frac_steps;

endmodule

`default_nettype wire

@@ src/stc_checker.sv @@
// ----------------------------------------------------------------------------
// stc_checker
// port-level checks of the timecode block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sample_count_to_timecode_macros.svh"

module stc_checker
	import stc_pkg::*;
(
	input logic                            clk,
	input logic                            arst_n,
	input logic                            position_stall,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic                            negative,
	input logic [HOURS_W-1:0]              hours,
	input logic [MS_W-1:0]                 minutes,
	input logic [MS_W-1:0]                 seconds,
	input logic [RATE_W-1:0]               fraction,
	input logic [RATE_W-1:0]               frac_steps
);

	logic       held;
	res_t       res_bus;
	logic       fields_ok;

	// a result shown but not taken
	assign held    = result_valid && result_stall;
	assign res_bus = {negative, hours, minutes, seconds, fraction, frac_steps};

	// minutes and seconds stay in range, fraction stays below its unit
	assign fields_ok = minutes < 6'd60 && seconds < 6'd60
		&& (frac_steps == '0 || fraction < frac_steps);

	// a held result keeps valid and every field
	`STC_ASSERT_NEXT(a_result_hold, clk, arst_n, held, result_valid && $stable(res_bus), "result moved while held")

	// the input only stalls after a result was held back
	`STC_ASSERT_SAME(a_stall_cause, clk, arst_n, position_stall, $past(held), "stall without a held result")

	// the skid item leaves once the result side is free
	`STC_ASSERT_NEXT(a_stall_release, clk, arst_n, position_stall && !result_stall, !position_stall, "stall outlived the item")

	`STC_ASSERT_SAME(a_field_range, clk, arst_n, result_valid, fields_ok, "result field out of range")

endmodule

bind sample_count_to_timecode stc_checker u_stc_checker (.*);

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// regression bench for the sample position to timecode converter: a queue-fed
// driver sends signed positions with random gaps, a monitor takes results
// under random stalls and checks every field against a local timecode
// predictor, over a series of sample rate and fraction mode settings
// ----------------------------------------------------------------------------

module tb;
	import stc_pkg::*;

	// pipeline depth from accept to result; settle adds margin for the final wait
	localparam int DUT_LATENCY = POSITION_BITS + RATE_W + 3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 125;
	// mode 3 has no name in the package; it counts samples
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
	localparam logic [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]          cfg_index = '0;
	logic [RATE_W-1:0]               cfg_data = '0;
	logic                            position_valid = 1'b0;
	logic                            position_stall;
	logic signed [POSITION_BITS-1:0] position = '0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	logic                            negative;
	logic [HOURS_W-1:0]              hours;
	logic [MS_W-1:0]                 minutes;
	logic [MS_W-1:0]                 seconds;
	logic [RATE_W-1:0]               fraction;
	logic [RATE_W-1:0]               frac_steps;

	// local copy of the configuration registers
	logic [RATE_W-1:0] model_rate = RATE_W'(RESET_RATE);
	logic [MODE_W-1:0] model_mode = MODE_SAMPLES;

	logic [POSITION_BITS-1:0] pending_positions[$];
	res_t                     expected_codes[$];

	int  mismatches = 0;
	int  items_sent = 0;
	int  results_checked = 0;
	int  settings_written = 0;
	int  cycle_count = 0;
	int  tx_gap = 0;
	int  tx_wait;
	int  rx_hold = 0;
	int  rx_wait;
	bit  tx_calm = 1'b0;
	bit  rx_calm = 1'b0;
	res_t rx_want;

	sample_count_to_timecode dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.position_valid (position_valid),
		.position_stall (position_stall),
		.position       (position),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.negative       (negative),
		.hours          (hours),
		.minutes        (minutes),
		.seconds        (seconds),
		.fraction       (fraction),
		.frac_steps     (frac_steps)
	);

	always #1 clk = ~clk;

	// expected timecode of one position under the given rate and mode
	function automatic res_t timecode_of(
		input logic [POSITION_BITS-1:0] raw,
		input logic [RATE_W-1:0]        rate,
		input logic [MODE_W-1:0]        mode
	);
		logic [POSITION_BITS-1:0] absval;
		logic [63:0]              mag;
		logic [63:0]              rem;
		logic [63:0]              scaled;
		logic [63:0]              whole;
		logic [31:0]              secs;
		logic [31:0]              mins;
		logic [RATE_W-1:0]        unit;
		res_t                     r;
		r = '0;
		r.negative = raw[POSITION_BITS-1];
		// two's complement magnitude; the most negative value stays 2^(N-1)
		absval = r.negative ? (~raw + 1'b1) : raw;
		mag = 64'(absval);
		case (mode)
			MODE_MSEC:   unit = RATE_W'(MSEC_UNIT);
			MODE_FRAMES: unit = RATE_W'(FRAMES_UNIT);
			default:     unit = rate;
		endcase
		r.frac_steps = unit;
		if (rate != '0) begin
			whole = mag / 64'(rate);
			rem = mag % 64'(rate);
			secs = whole[31:0];
			mins = secs / 32'(SIXTY);
			r.hours = HOURS_W'(mins / 32'(SIXTY));
			r.minutes = MS_W'(mins % 32'(SIXTY));
			r.seconds = MS_W'(secs % 32'(SIXTY));
			scaled = (rem * 64'(unit)) / 64'(rate);
			r.fraction = scaled[RATE_W-1:0];
		end
		return r;
	endfunction

	// random position: full range, small, near second or hour boundaries, within a day, or extreme
	function automatic logic [POSITION_BITS-1:0] pick_position(input logic [RATE_W-1:0] rate);
		logic [63:0]              wide;
		logic [63:0]              base;
		logic [POSITION_BITS-1:0] p;
		wide = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: p = wide[POSITION_BITS-1:0];
			1: p = POSITION_BITS'(wide % (64'(rate) * 2 + 1));
			2: begin
				base = 64'(rate) * 64'($urandom_range(0, 4000));
				p = POSITION_BITS'(base + 64'($urandom_range(0, 2)) - 1);
			end
			3: begin
				base = 64'(rate) * 3600 * 64'($urandom_range(0, 300));
				p = POSITION_BITS'(base + 64'($urandom_range(0, 2)) - 1);
			end
			4: p = POSITION_BITS'(wide % (64'(rate) * 86400 + 1));
			default: p = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
		endcase
		if ($urandom_range(0, 1) == 1)
			p = -p;
		return p;
	endfunction

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 8));
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch: %s got %0d expected %0d (result %0d)", what, got, want,
			results_checked);
		mismatches++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [RATE_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SAMPLE_RATE)
			model_rate = value;
		else
			model_mode = value[MODE_W-1:0];
	endtask

	task automatic set_config(input logic [RATE_W-1:0] rate, input logic [MODE_W-1:0] mode);
		write_reg(REG_SAMPLE_RATE, rate);
		write_reg(REG_FRACTION_MODE, RATE_W'(mode));
		settings_written++;
	endtask

	// hold off until every item is sent and every result is back, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		while (pending_positions.size() != 0 || position_valid || expected_codes.size() != 0)
			@(negedge clk);
		repeat (DUT_LATENCY + 8) @(posedge clk);
	endtask

	task automatic queue_random(input int n);
		@(negedge clk);
		repeat (n) pending_positions.push_back(pick_position(model_rate));
	endtask

	// driver: presents queued positions, waits a drawn number of cycles between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_valid <= 1'b0;
			position <= '0;
			tx_gap <= 0;
		end else if (position_valid && !position_stall) begin
			expected_codes.push_back(timecode_of(position, model_rate, model_mode));
			items_sent++;
			tx_wait = draw_wait(tx_calm);
			if (tx_wait == 0 && pending_positions.size() != 0) begin
				position <= pending_positions.pop_front();
			end else begin
				position_valid <= 1'b0;
				tx_gap <= (tx_wait == 0) ? 0 : tx_wait - 1;
			end
		end else if (!position_valid) begin
			if (tx_gap != 0) begin
				tx_gap <= tx_gap - 1;
			end else if (pending_positions.size() != 0) begin
				position <= pending_positions.pop_front();
				position_valid <= 1'b1;
			end
		end
	end

	// monitor: stalls for a drawn number of cycles after each item, checks every field
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			rx_hold <= 0;
		end else if (result_valid && !result_stall) begin
			if (expected_codes.size() == 0) begin
				report_mismatch("result with nothing expected", 64'(hours), 64'd0);
			end else begin
				rx_want = expected_codes.pop_front();
				if (negative !== rx_want.negative)
					report_mismatch("negative", 64'(negative), 64'(rx_want.negative));
				if (hours !== rx_want.hours)
					report_mismatch("hours", 64'(hours), 64'(rx_want.hours));
				if (minutes !== rx_want.minutes)
					report_mismatch("minutes", 64'(minutes), 64'(rx_want.minutes));
				if (seconds !== rx_want.seconds)
					report_mismatch("seconds", 64'(seconds), 64'(rx_want.seconds));
				if (fraction !== rx_want.fraction)
					report_mismatch("fraction", 64'(fraction), 64'(rx_want.fraction));
				if (frac_steps !== rx_want.frac_steps)
					report_mismatch("frac_steps", 64'(frac_steps),
						64'(rx_want.frac_steps));
			end
			results_checked++;
			rx_wait = draw_wait(rx_calm);
			rx_hold <= rx_wait;
			result_stall <= (rx_wait != 0);
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			result_stall <= (rx_hold > 1);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_codes.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 48000 samples per second, fraction in samples
		@(negedge clk);
		pending_positions.push_back('0);
		pending_positions.push_back(POSITION_BITS'(1));
		pending_positions.push_back(POSITION_BITS'(-1));
		pending_positions.push_back(POSITION_BITS'(47999));
		pending_positions.push_back(POSITION_BITS'(48000));
		pending_positions.push_back(POSITION_BITS'(-48000));
		pending_positions.push_back(POSITION_BITS'(48000 * 60 - 1));
		pending_positions.push_back(POSITION_BITS'(48000 * 3600));
		// 256 hours wraps to zero
		pending_positions.push_back(POSITION_BITS'(64'd44236800000));
		pending_positions.push_back(POS_MAX);
		pending_positions.push_back(POS_MIN);
		settle();

		// zero rate: only sign and unit come through
		set_config('0, MODE_SAMPLES);
		@(negedge clk);
		pending_positions.push_back(POSITION_BITS'(12345));
		pending_positions.push_back(POSITION_BITS'(-7));
		settle();

		// unused mode counts samples
		set_config(RATE_W'(1000), MODE_UNUSED);
		@(negedge clk);
		pending_positions.push_back(POSITION_BITS'(1500));
		pending_positions.push_back(POSITION_BITS'(-2999));
		settle();

		// one sample per second: second count overflows 32 bits
		set_config(RATE_W'(1), MODE_MSEC);
		@(negedge clk);
		pending_positions.push_back(POS_MAX);
		pending_positions.push_back(POS_MIN);
		settle();

		// widest rate field
		set_config({RATE_W{1'b1}}, MODE_FRAMES);
		@(negedge clk);
		pending_positions.push_back(POSITION_BITS'(1048574));
		pending_positions.push_back(POSITION_BITS'(-1048575));
		settle();

		set_config(RATE_W'(768000), MODE_MSEC);
		@(negedge clk);
		pending_positions.push_back(POSITION_BITS'(767999));
		pending_positions.push_back(POSITION_BITS'(64'd768000 * 3600 * 255 + 64'd767999));
		settle();

		// random phases, one setting each, some with no idling on either side
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 7))
				0: set_config(RATE_W'(1), MODE_W'(ph % 4));
				1: set_config(RATE_W'(768000), MODE_W'(ph % 4));
				2: set_config({RATE_W{1'b1}}, MODE_W'(ph % 4));
				3: set_config(RATE_W'(48000), MODE_W'(ph % 4));
				4: set_config(RATE_W'(44100), MODE_W'(ph % 4));
				5: set_config(RATE_W'($urandom_range(1, 1048575)), MODE_W'(ph % 4));
				6: set_config(RATE_W'($urandom_range(1, 200)), MODE_W'(ph % 4));
				default: set_config('0, MODE_W'(ph % 4));
			endcase
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			queue_random(PHASE_ITEMS);
			settle();
		end

		$display("sent %0d positions over %0d register settings, checked %0d results",
			items_sent, settings_written, results_checked);
		$display("rates from zero to full scale, all four fraction modes, %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/stc_pkg.sv
src/stc_sec_div.sv
src/stc_hms.sv
src/stc_frac.sv
src/sample_count_to_timecode.sv
src/stc_checker.sv
bench/tb.sv
